// ===== rtl/bxt_pkg.sv =====
// Shared types, constants and walk helpers for the binary xor trie.
package bxt_pkg;

  // Key width and node pool size
  localparam int KEY_BITS   = 18;
  localparam int NODE_COUNT = 16384;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = $clog2(KEY_BITS);

  typedef logic [IDX_W-1:0]    link_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [LVL_W-1:0]    lvl_t;
  typedef logic [KEY_BITS-1:0] key_t;

  // One pool entry: child link per key bit value, zero means no child
  typedef struct packed {
    link_t lnk1;
    link_t lnk0;
  } node_t;

  // Operation codes on the input beat
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_FILL,
    S_QRY_WALK,
    S_DONE
  } state_t;

  // Outcome of one query level
  typedef struct packed {
    logic  acc_bit;
    logic  moved;
    link_t nx;
  } step_t;

  function automatic link_t link_sel(node_t n, logic b);
    return b ? n.lnk1 : n.lnk0;
  endfunction

  function automatic node_t link_set(node_t n, logic b, link_t v);
    node_t r;
    r = n;
    if (b) begin
      r.lnk1 = v;
    end else begin
      r.lnk0 = v;
    end
    return r;
  endfunction

  // Prefer the child for (bit ^ flip); fall back to the other one, or stay put
  function automatic step_t walk_step(node_t n, logic b, logic flip);
    step_t s;
    logic  want;
    link_t lw;
    link_t lo;
    want = b ^ flip;
    lw   = link_sel(n, want);
    lo   = link_sel(n, ~want);
    if (lw != '0) begin
      s.acc_bit = flip;
      s.moved   = 1'b1;
      s.nx      = lw;
    end else begin
      s.acc_bit = ~flip;
      s.moved   = (lo != '0);
      s.nx      = lo;
    end
    return s;
  endfunction

endpackage

// ===== rtl/bxt_if.sv =====
// Valid/ready channel interfaces for the trie's request and result beats.
interface bxt_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [bxt_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface bxt_out_if;
  logic                         valid;
  logic                         ready;
  logic [bxt_pkg::KEY_BITS-1:0] max_xor;
  logic [bxt_pkg::KEY_BITS-1:0] min_xor;
  logic [1:0]                   status;

  modport source (output valid, output max_xor, output min_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input min_xor, input status, output ready);
endinterface

// ===== rtl/binary_xor_trie_core.sv =====
// Binary xor trie core: insert, max/min xor query and clear over a node pool.
//
// The block keeps an 18-level binary trie of 18-bit keys in a 16384-entry node
// pool (one write port, two registered read ports); the root lives in flops.
// One request beat is taken at a time and the input is not ready until the
// result beat has been handed to the output register. The walk covers one trie
// level per cycle, bounded by the registered pool read. A query runs its max
// and min walks side by side on the two read ports. An insert's walk stops at
// the first missing link, then makes one pool write per newly allocated node;
// a duplicate key walks the full path. Clear, a query on an empty trie and an
// unknown kind go straight to the result state. Output back-pressure can hold
// any request in the result state. An insert that needs more nodes than remain
// is rejected whole with status pool full. No clearing pass is needed.
module binary_xor_trie_core (
  input  logic       clk,
  input  logic       rst_n,
  bxt_in_if.sink     in_bus,
  bxt_out_if.source  out_bus
);
  import bxt_pkg::*;

  // Node pool
  node_t   node_mem [NODE_COUNT];

  // Control state
  state_t  state_r, state_nxt;
  node_t   root_r;
  cnt_t    next_free_r;
  logic    empty_r;
  logic    out_valid_r;

  // Datapath
  key_t    key_r;
  lvl_t    lvl_r;
  logic    a_root_r, b_root_r;
  link_t   a_node_r, b_node_r;
  node_t   rd_a_r, rd_b_r;
  key_t    acc_max_r, acc_min_r;
  status_t status_r;
  key_t    out_max_r, out_min_r;
  status_t out_status_r;

  // Combinational
  node_t   links_a, links_b;
  logic    key_bit;
  lvl_t    lvl_dn;
  link_t   ins_nx;
  logic    [CNT_W:0] ins_end;
  logic    ins_fits;
  logic    ins_alloc;
  step_t   step_a, step_b;
  logic    last_lvl;
  logic    in_fire, out_fire, out_free;
  logic    in_ready;
  logic    mem_we;
  link_t   mem_waddr;
  node_t   mem_wdata;
  link_t   raddr_a, raddr_b;

  // Current node links for each walker
  assign links_a  = a_root_r ? root_r : rd_a_r;
  assign links_b  = b_root_r ? root_r : rd_b_r;
  assign key_bit  = key_r[lvl_r];
  assign lvl_dn   = lvl_r - lvl_t'(1);
  assign last_lvl = (lvl_r == '0);

  // Insert: follow the key; on a missing link check room for the rest of the path
  assign ins_nx    = link_sel(links_a, key_bit);
  assign ins_end   = {1'b0, next_free_r} + (CNT_W+1)'(lvl_r) + (CNT_W+1)'(1);
  assign ins_fits  = (ins_end <= (CNT_W+1)'(NODE_COUNT));
  assign ins_alloc = (state_r == S_INS_WALK) && (ins_nx == '0) && ins_fits;

  // Query: max walk prefers the opposite bit, min walk the equal bit
  assign step_a = walk_step(links_a, key_bit, 1'b1);
  assign step_b = walk_step(links_b, key_bit, 1'b0);

  // Handshakes
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_valid_r && out_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready    = in_ready;
  assign out_bus.valid   = out_valid_r;
  assign out_bus.max_xor = out_max_r;
  assign out_bus.min_xor = out_min_r;
  assign out_bus.status  = out_status_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          case (kind_t'(in_bus.kind))
            KIND_INSERT: state_nxt = S_INS_WALK;
            KIND_QUERY:  state_nxt = empty_r ? S_DONE : S_QRY_WALK;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_WALK: begin
        if (ins_nx != '0) begin
          if (last_lvl) begin
            state_nxt = S_DONE;
          end
        end else if (ins_fits) begin
          state_nxt = S_INS_FILL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_FILL: begin
        if (last_lvl) begin
          state_nxt = S_DONE;
        end
      end
      S_QRY_WALK: begin
        if (last_lvl) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: ready, pool write and read addresses
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = a_node_r;
    mem_wdata = link_set(links_a, key_bit, next_free_r[IDX_W-1:0]);
    raddr_a   = a_node_r;
    raddr_b   = b_node_r;
    case (state_r)
      S_INS_WALK: begin
        raddr_a = ins_nx;
        // hook the new branch onto a pool node; root hooks go to flops
        mem_we  = ins_alloc && !a_root_r;
      end
      S_INS_FILL: begin
        // each new node links to the next one down, the leaf has no children
        mem_we    = 1'b1;
        mem_waddr = next_free_r[IDX_W-1:0];
        mem_wdata = '0;
        if (!last_lvl) begin
          mem_wdata = link_set(node_t'('0), key_r[lvl_dn],
                               next_free_r[IDX_W-1:0] + link_t'(1));
        end
      end
      S_QRY_WALK: begin
        raddr_a = step_a.moved ? step_a.nx : a_node_r;
        raddr_b = step_b.moved ? step_b.nx : b_node_r;
      end
      default: ;
    endcase
  end

  // Node pool: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= node_mem[raddr_a];
    rd_b_r <= node_mem[raddr_b];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      root_r      <= '0;
      next_free_r <= cnt_t'(1);
      empty_r     <= 1'b1;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      // clear empties the root and rewinds the allocator
      if (in_fire && in_bus.kind == KIND_CLEAR) begin
        root_r      <= '0;
        next_free_r <= cnt_t'(1);
        empty_r     <= 1'b1;
      end

      if (ins_alloc && a_root_r) begin
        root_r <= link_set(root_r, key_bit, next_free_r[IDX_W-1:0]);
      end

      if (state_r == S_INS_FILL) begin
        next_free_r <= next_free_r + cnt_t'(1);
      end

      // any accepted insert leaves at least one key stored
      if (ins_alloc || (state_r == S_INS_WALK && ins_nx != '0 && last_lvl)) begin
        empty_r <= 1'b0;
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r     <= in_bus.key;
      lvl_r     <= lvl_t'(KEY_BITS - 1);
      a_root_r  <= 1'b1;
      b_root_r  <= 1'b1;
      acc_max_r <= '0;
      acc_min_r <= '0;
      status_r  <= (in_bus.kind == KIND_QUERY && empty_r) ? ST_EMPTY : ST_OK;
    end

    case (state_r)
      S_INS_WALK: begin
        if (ins_nx != '0) begin
          a_root_r <= 1'b0;
          a_node_r <= ins_nx;
          if (!last_lvl) begin
            lvl_r <= lvl_dn;
          end
        end else if (!ins_fits) begin
          status_r <= ST_FULL;
        end
      end
      S_INS_FILL: begin
        if (!last_lvl) begin
          lvl_r <= lvl_dn;
        end
      end
      S_QRY_WALK: begin
        acc_max_r[lvl_r] <= step_a.acc_bit;
        acc_min_r[lvl_r] <= step_b.acc_bit;
        if (step_a.moved) begin
          a_root_r <= 1'b0;
          a_node_r <= step_a.nx;
        end
        if (step_b.moved) begin
          b_root_r <= 1'b0;
          b_node_r <= step_b.nx;
        end
        if (!last_lvl) begin
          lvl_r <= lvl_dn;
        end
      end
      default: ;
    endcase

    // result beat register
    if (state_r == S_DONE && out_free) begin
      out_max_r    <= acc_max_r;
      out_min_r    <= acc_min_r;
      out_status_r <= status_r;
    end
  end

  // Checks
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= cnt_t'(NODE_COUNT))
    else $error("node allocator ran past the pool");

  a_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INS_WALK || state_r == S_INS_FILL))
    else $error("pool written outside an insert");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.kind == KIND_CLEAR) |=> (empty_r && next_free_r == cnt_t'(1)))
    else $error("clear did not empty the trie");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_max_r == '0 && out_min_r == '0))
    else $error("failed beat carries nonzero xor");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the binary xor trie core: insert, max/min xor query and clear.
module tb_top;
  import bxt_pkg::*;

  // Kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without any accepted beat before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // Drain time after the last expected result (longest insert plus margin)
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    key_t    mx;
    key_t    mn;
    status_t st;
  } xor_result_t;

  // Mirror of the node pool plus the queue of results still owed by the block
  class trie_mirror;
    link_t         lnk0 [NODE_COUNT];
    link_t         lnk1 [NODE_COUNT];
    int unsigned   next_free;
    bit            is_empty;
    key_t          live_keys[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    xor_result_t   pending_xor[$];

    function new();
      mismatches   = 0;
      results_seen = 0;
      clear_trie();
    endfunction

    function void clear_trie();
      lnk0[0]   = '0;
      lnk1[0]   = '0;
      next_free = 1;
      is_empty  = 1'b1;
      live_keys.delete();
    endfunction

    function link_t child(link_t n, bit b);
      return b ? lnk1[n] : lnk0[n];
    endfunction

    // Insert is all or nothing: count missing nodes first, then allocate
    function status_t add_key(key_t k);
      link_t n;
      link_t nx;
      int    need;
      n    = '0;
      need = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        nx = child(n, k[i]);
        if (nx == '0) begin
          need = i + 1;
          break;
        end
        n = nx;
      end
      if (next_free + need > NODE_COUNT) begin
        return ST_FULL;
      end
      n = '0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        nx = child(n, k[i]);
        if (nx == '0) begin
          nx = link_t'(next_free);
          next_free++;
          lnk0[nx] = '0;
          lnk1[nx] = '0;
          if (k[i]) lnk1[n] = nx;
          else      lnk0[n] = nx;
        end
        n = nx;
      end
      if (need != 0) live_keys.push_back(k);
      is_empty = 1'b0;
      return ST_OK;
    endfunction

    // Greedy walk: flip=1 looks for the largest xor, flip=0 for the smallest
    function key_t best_xor(key_t k, bit flip);
      link_t n;
      link_t nx;
      key_t  acc;
      bit    want;
      n   = '0;
      acc = '0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        want = k[i] ^ flip;
        nx   = child(n, want);
        if (nx != '0) begin
          acc[i] = want ^ k[i];
          n      = nx;
        end else begin
          nx     = child(n, ~want);
          acc[i] = ~want ^ k[i];
          if (nx != '0) n = nx;
        end
      end
      return acc;
    endfunction

    function void note_request(logic [1:0] kind, key_t k);
      xor_result_t r;
      r    = '0;
      r.st = ST_OK;
      case (kind)
        KIND_INSERT: r.st = add_key(k);
        KIND_QUERY: begin
          if (is_empty) begin
            r.st = ST_EMPTY;
          end else begin
            r.mx = best_xor(k, 1'b1);
            r.mn = best_xor(k, 1'b0);
          end
        end
        KIND_CLEAR: clear_trie();
        default: ;
      endcase
      pending_xor.push_back(r);
    endfunction

    function void check_result(key_t mx, key_t mn, logic [1:0] st);
      xor_result_t e;
      results_seen++;
      if (pending_xor.size() == 0) begin
        if (mismatches < 10)
          $display("result %0d: unexpected beat max %05h min %05h status %0d",
                   results_seen, mx, mn, st);
        mismatches++;
        return;
      end
      e = pending_xor.pop_front();
      if (mx !== e.mx || mn !== e.mn || st !== e.st) begin
        if (mismatches < 10)
          $display("result %0d: max %05h/%05h min %05h/%05h status %0d/%0d (exp/got)",
                   results_seen, e.mx, mx, e.mn, mn, e.st, st);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   hang_cnt = 0;

  trie_mirror trie;

  bxt_in_if  in_bus();
  bxt_out_if out_bus();

  binary_xor_trie_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side: random back-pressure, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      trie.check_result(out_bus.max_xor, out_bus.min_xor, out_bus.status);
    end
    out_bus.ready <= calm || ($urandom_range(99) >= 19);
  end

  // Hang watchdog: counts cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("binary_xor_trie_core regression: fail");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  // Drive one request beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(input logic [1:0] kind, input key_t k);
    while (!calm && $urandom_range(99) < 19) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind  <= kind;
    in_bus.key   <= k;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    trie.note_request(kind, k);
  endtask

  // Keys biased toward stored keys, their near neighbors and the field extremes
  function automatic key_t pick_key();
    int   roll;
    key_t base;
    roll = $urandom_range(99);
    if (trie.live_keys.size() != 0) begin
      base = trie.live_keys[$urandom_range(trie.live_keys.size() - 1)];
    end else begin
      base = key_t'($urandom);
    end
    if (roll < 35) return key_t'($urandom);
    if (roll < 60) return base;
    if (roll < 85) return base ^ (key_t'(1) << $urandom_range(KEY_BITS - 1));
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return key_t'(1) << $urandom_range(KEY_BITS - 1);
      default: return ~(key_t'(1) << $urandom_range(KEY_BITS - 1));
    endcase
  endfunction

  task automatic run_mix(input int count, input bit allow_clear);
    int         roll;
    logic [1:0] kind;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 48)                      kind = KIND_INSERT;
      else if (roll < 92)                 kind = KIND_QUERY;
      else if (roll < 96 && allow_clear)  kind = KIND_CLEAR;
      else                                kind = KIND_UNUSED;
      send_beat(kind, pick_key());
    end
  endtask

  // Stimulus
  initial begin
    trie          = new();
    calm          = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_INSERT;
    in_bus.key    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queries, ignored kind, extremes, duplicates, clear
    send_beat(KIND_QUERY,  18'h00000);
    send_beat(KIND_QUERY,  18'h3ffff);
    send_beat(KIND_UNUSED, 18'h2aaaa);
    send_beat(KIND_INSERT, 18'h00000);
    send_beat(KIND_INSERT, 18'h3ffff);
    send_beat(KIND_INSERT, 18'h00000);
    send_beat(KIND_QUERY,  18'h00000);
    send_beat(KIND_QUERY,  18'h3ffff);
    send_beat(KIND_QUERY,  18'h2aaaa);
    send_beat(KIND_QUERY,  18'h15555);
    send_beat(KIND_INSERT, 18'h20000);
    send_beat(KIND_QUERY,  18'h1ffff);
    send_beat(KIND_CLEAR,  18'h3ffff);
    send_beat(KIND_QUERY,  18'h00005);
    send_beat(KIND_UNUSED, 18'h3ffff);
    send_beat(KIND_INSERT, 18'h15555);
    send_beat(KIND_QUERY,  18'h15555);
    send_beat(KIND_QUERY,  18'h2aaaa);
    send_beat(KIND_CLEAR,  18'h00000);
    send_beat(KIND_CLEAR,  18'h15555);
    send_beat(KIND_INSERT, 18'h00001);
    send_beat(KIND_INSERT, 18'h00002);
    send_beat(KIND_QUERY,  18'h00003);

    // Random mix with idling on both sides, then a stretch without idling
    run_mix(250, 1'b1);
    calm = 1'b1;
    run_mix(120, 1'b1);
    calm = 1'b0;

    // Restart from an empty trie
    send_beat(KIND_CLEAR, '0);
    run_mix(100, 1'b1);

    in_bus.valid <= 1'b0;
    while (trie.pending_xor.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (trie.mismatches == 0) begin
      $display("binary_xor_trie_core regression: pass");
    end else begin
      $display("binary_xor_trie_core regression: fail");
    end
    $finish;
  end

endmodule
